/* rtl/mutf8_pkg.sv */
// ----------------------------------------------------------------------------
// mutf8_pkg
// Shared types, constants and encode helpers for the UTF-8 to modified UTF-8
// encoder.
// ----------------------------------------------------------------------------
package mutf8_pkg;

  // Replacement character U+FFFD as three UTF-8 bytes
  localparam logic [7:0] FFFD_B0 = 8'hEF;
  localparam logic [7:0] FFFD_B1 = 8'hBF;
  localparam logic [7:0] FFFD_B2 = 8'hBD;

  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [15:0] HI_SURR   = 16'hD800;
  localparam logic [15:0] LO_SURR   = 16'hDC00;

  // Most bytes one code point can produce (surrogate pair)
  localparam int unsigned CODE_BYTES = 6;

  // Encoded code point: bytes in send order and byte count
  typedef struct packed {
    logic [CODE_BYTES-1:0][7:0] bytes;
    logic [2:0]                 len;
  } enc_t;

  // One item's output run: replacement chars first, then the code bytes
  typedef struct packed {
    logic [2:0]                 n_fffd;
    logic [2:0]                 code_len;
    logic [CODE_BYTES-1:0][7:0] code_bytes;
    logic                       last;
  } job_t;

  // Byte of U+FFFD at position pos
  function automatic logic [7:0] fffd_byte(input logic [1:0] pos);
    logic [7:0] b;
    unique case (pos)
      2'd0:    b = FFFD_B0;
      2'd1:    b = FFFD_B1;
      2'd2:    b = FFFD_B2;
      default: b = FFFD_B2;
    endcase
    return b;
  endfunction

  // Encode a 21-bit code point: NUL as C0 80, supplementary as two
  // 3-byte surrogates, everything else in shortest form
  function automatic enc_t encode_code(input logic [20:0] cp);
    enc_t        e;
    logic [20:0] v;
    logic [15:0] hi;
    logic [15:0] lo;
    e.bytes = '0;
    e.len   = '0;
    v  = cp - SUPP_BASE;
    hi = HI_SURR + {5'd0, v[20:10]};
    lo = LO_SURR + {6'd0, v[9:0]};
    if (cp == 21'd0) begin
      e.bytes[0] = 8'hC0;
      e.bytes[1] = 8'h80;
      e.len      = 3'd2;
    end else if (cp >= SUPP_BASE) begin
      e.bytes[0] = {4'hE, hi[15:12]};
      e.bytes[1] = {2'b10, hi[11:6]};
      e.bytes[2] = {2'b10, hi[5:0]};
      e.bytes[3] = {4'hE, lo[15:12]};
      e.bytes[4] = {2'b10, lo[11:6]};
      e.bytes[5] = {2'b10, lo[5:0]};
      e.len      = 3'd6;
    end else if (cp < 21'h80) begin
      e.bytes[0] = {1'b0, cp[6:0]};
      e.len      = 3'd1;
    end else if (cp < 21'h800) begin
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
      e.len      = 3'd2;
    end else begin
      e.bytes[0] = {4'hE, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
      e.len      = 3'd3;
    end
    return e;
  endfunction

endpackage

/* rtl/mutf8_decoder.sv */
// ----------------------------------------------------------------------------
// mutf8_decoder
// Holds the partial UTF-8 sequence and turns each input byte into a job:
// a count of replacement characters and an encoded code point.
// ----------------------------------------------------------------------------
module mutf8_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  input  logic               accept,
  output mutf8_pkg::job_t    job,
  output logic               job_nonempty
);
  import mutf8_pkg::*;

  logic [1:0]  held;
  logic [2:0]  exp_len;
  logic [20:0] partial;
  logic [1:0]  held_next;
  logic [2:0]  exp_len_next;
  logic [20:0] partial_next;

  logic        is_cont;
  logic [2:0]  held_inc;
  logic [20:0] partial_shift;
  logic [1:0]  pre;
  logic        stray;
  logic [1:0]  post;
  logic        has_code;
  logic [20:0] code_cp;
  enc_t        enc;

  assign is_cont       = (in_byte[7:6] == 2'b10);
  assign held_inc      = {1'b0, held} + 3'd1;
  assign partial_shift = {partial[14:0], in_byte[5:0]};

  // Work out the next sequence state and what this byte emits
  always_comb begin
    held_next    = held;
    exp_len_next = exp_len;
    partial_next = partial;
    pre          = 2'd0;
    stray        = 1'b0;
    post         = 2'd0;
    has_code     = 1'b0;
    code_cp      = '0;
    if (held != 2'd0 && is_cont) begin
      if (held_inc >= exp_len) begin
        has_code     = 1'b1;
        code_cp      = partial_shift;
        held_next    = 2'd0;
        exp_len_next = 3'd0;
        partial_next = '0;
      end else begin
        held_next    = held_inc[1:0];
        partial_next = partial_shift;
      end
    end else begin
      // Flush any broken sequence, then treat the byte as a lead
      pre          = held;
      held_next    = 2'd0;
      exp_len_next = 3'd0;
      partial_next = '0;
      priority if (in_byte[7] == 1'b0) begin
        has_code = 1'b1;
        code_cp  = {13'd0, in_byte};
      end else if (in_byte[7:5] == 3'b110) begin
        partial_next = {16'd0, in_byte[4:0]};
        held_next    = 2'd1;
        exp_len_next = 3'd2;
      end else if (in_byte[7:4] == 4'b1110) begin
        partial_next = {17'd0, in_byte[3:0]};
        held_next    = 2'd1;
        exp_len_next = 3'd3;
      end else if (in_byte[7:3] == 5'b11110) begin
        partial_next = {18'd0, in_byte[2:0]};
        held_next    = 2'd1;
        exp_len_next = 3'd4;
      end else begin
        stray = 1'b1;
      end
    end
    // End of string drops whatever is still held
    if (in_last) begin
      post         = held_next;
      held_next    = 2'd0;
      exp_len_next = 3'd0;
      partial_next = '0;
    end
  end

  // Build the job for the emitter
  always_comb begin
    enc            = encode_code(code_cp);
    job.n_fffd     = {1'b0, pre} + {2'b00, stray} + {1'b0, post};
    job.code_len   = has_code ? enc.len : 3'd0;
    job.code_bytes = enc.bytes;
    job.last       = in_last;
    job_nonempty   = (job.n_fffd != 3'd0) || has_code;
  end

  // Advance the sequence state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      held    <= 2'd0;
      exp_len <= 3'd0;
      partial <= '0;
    end else if (accept) begin
      held    <= held_next;
      exp_len <= exp_len_next;
      partial <= partial_next;
    end
  end

endmodule

/* rtl/mutf8_emitter.sv */
// ----------------------------------------------------------------------------
// mutf8_emitter
// Holds one job and walks it out one byte per beat into the output register.
// ----------------------------------------------------------------------------
module mutf8_emitter (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_push,
  input  mutf8_pkg::job_t    job_in,
  output logic               job_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_run_last,
  output logic               out_string_end
);
  import mutf8_pkg::*;

  job_t       job;
  logic       job_valid;
  logic [2:0] fffd_left;
  logic [1:0] fffd_pos;
  logic [2:0] code_pos;

  logic       load_ok;
  logic       advance;
  logic       is_final;
  logic [7:0] code_byte;
  logic [7:0] cur_byte;

  assign load_ok   = !out_valid || out_ready;
  assign advance   = job_valid && load_ok;
  assign job_ready = !job_valid || (load_ok && is_final);

  // Pick the current code byte
  always_comb begin
    unique case (code_pos)
      3'd0:    code_byte = job.code_bytes[0];
      3'd1:    code_byte = job.code_bytes[1];
      3'd2:    code_byte = job.code_bytes[2];
      3'd3:    code_byte = job.code_bytes[3];
      3'd4:    code_byte = job.code_bytes[4];
      3'd5:    code_byte = job.code_bytes[5];
      default: code_byte = 8'h00;
    endcase
  end

  // Replacement characters go out first, then the code bytes
  always_comb begin
    cur_byte = (fffd_left != 3'd0) ? fffd_byte(fffd_pos) : code_byte;
    is_final = ((fffd_left == 3'd1) && (fffd_pos == 2'd2) && (job.code_len == 3'd0)) ||
               ((fffd_left == 3'd0) && (code_pos == job.code_len - 3'd1));
  end

  // Load a new job or step through the current one
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (job_push) begin
      job_valid <= 1'b1;
    end else if (advance && is_final) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_push) begin
      job       <= job_in;
      fffd_left <= job_in.n_fffd;
      fffd_pos  <= 2'd0;
      code_pos  <= 3'd0;
    end else if (advance) begin
      if (fffd_left != 3'd0) begin
        if (fffd_pos == 2'd2) begin
          fffd_pos  <= 2'd0;
          fffd_left <= fffd_left - 3'd1;
        end else begin
          fffd_pos <= fffd_pos + 2'd1;
        end
      end else begin
        code_pos <= code_pos + 3'd1;
      end
    end
  end

  // Output register: fill on advance, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte       <= cur_byte;
      out_run_last   <= is_final;
      out_string_end <= is_final && job.last;
    end
  end

endmodule

/* rtl/utf8_to_modified_utf8_encoder_top.sv */
// ----------------------------------------------------------------------------
// utf8_to_modified_utf8_encoder_top
// Re-encodes a UTF-8 byte stream as Java modified UTF-8.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one UTF-8 byte per beat, with
//   in_last on the final byte of a string. Output channel (out_valid/
//   out_ready) carries one modified UTF-8 byte per beat; out_run_last marks
//   the last byte caused by an input byte and out_string_end the final byte
//   of the string. An input byte may cause no output (held in a sequence).
//   An accepted input byte is decoded combinationally and loaded into the job
//   register; its first output byte then moves from the job register into the
//   output register once that register is free or being drained.
//   Throughput: one output byte per cycle while out_ready stays high. An input
//   byte whose run is one byte long goes at one per cycle; after a longer run
//   the next input is let in only as the run's last byte moves, set by the
//   single job register walking its run a byte at a time.
//   Reset clears the held sequence, the job register and the output register.
//   When the receiver stalls, the output byte holds, the job register stops
//   advancing and in_ready stays low until the run's last byte moves.
// ----------------------------------------------------------------------------
module utf8_to_modified_utf8_encoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_string_end
);
  import mutf8_pkg::*;

  job_t job;
  logic job_nonempty;
  logic job_ready;
  logic accept;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;

  // Sequence tracking and re-encoding
  mutf8_decoder u_decoder (
    .clk          (clk),
    .rst          (rst),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .accept       (accept),
    .job          (job),
    .job_nonempty (job_nonempty)
  );

  // Byte serialization into the output register
  mutf8_emitter u_emitter (
    .clk            (clk),
    .rst            (rst),
    .job_push       (accept && job_nonempty),
    .job_in         (job),
    .job_ready      (job_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end)
  );

endmodule
